// File: design/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg: shared types and constants for sinogram bin addressing
// Register indexes, status codes, segment table entry and build state.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int RINGS        = 77;
  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
  localparam int FIRST_W      = SEG_AW + 6;
  localparam int NUM_PLANES   = 2 * RINGS - 1;
  localparam int PI_Q16       = 205887;

  localparam logic [15:0] VIEW_RECIP = 16'((64'd1 << 32) / PI_Q16);

  typedef enum logic [2:0] {
    REG_NUM_VIEWS     = 3'd0,
    REG_NUM_RADIAL    = 3'd1,
    REG_SPAN          = 3'd2,
    REG_MAX_RING_DIFF = 3'd3,
    REG_SEGMENT_SCALE = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_RADIAL  = 3'd1,
    STAT_SEGMENT = 3'd2,
    STAT_BELOW   = 3'd3,
    STAT_ABOVE   = 3'd4
  } status_t;

  typedef enum logic {
    BUILD_RUN,
    BUILD_DONE
  } build_state_t;

  typedef struct packed {
    logic [10:0] num_views;
    logic [10:0] num_radial;
    logic [4:0]  span;
    logic [7:0]  max_ring_diff;
    logic [23:0] segment_scale;
  } cfg_t;

  typedef struct packed {
    logic        in_table;
    logic [7:0]  first;
    logic [7:0]  count;
    logic [11:0] offset;
  } seg_entry_t;

  typedef struct packed {
    logic              en;
    logic [SEG_AW-1:0] addr;
    seg_entry_t        data;
  } tbl_wr_t;

endpackage

// File: design/sba_seg_mem.sv
// ----------------------------------------------------------------------------
// sba_seg_mem: segment table memory
// One write port from the table builder, one registered read port.
// ----------------------------------------------------------------------------
module sba_seg_mem
  import sba_pkg::*;
(
  input  logic              clk,
  input  tbl_wr_t           wr,
  input  logic              rd_en,
  input  logic [SEG_AW-1:0] rd_addr,
  output seg_entry_t        rd_data
);

  seg_entry_t mem [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/sba_table_build.sv
// ----------------------------------------------------------------------------
// sba_table_build: segment table sweep
// Writes one segment entry per cycle from span, ring difference and ring count.
// ----------------------------------------------------------------------------
module sba_table_build
  import sba_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    restart,
  output tbl_wr_t wr,
  output logic    busy
);

  build_state_t      state, state_next;
  logic [SEG_AW-1:0] entry;
  logic [11:0]       off;

  logic [4:0]         s_eff;
  logic [4:0]         half;
  logic [SEG_AW-1:0]  km1;
  logic [SEG_AW:0]    kup;
  logic [FIRST_W-1:0] first_full;
  logic [FIRST_W-1:0] k_span;
  logic [7:0]         first;
  logic [8:0]         two_first;
  logic [7:0]         count;
  logic [12:0]        off_sum;
  logic [11:0]        off_next;
  logic               in_table;

  always_comb begin
    s_eff      = (cfg.span == 5'd0) ? 5'd1 : cfg.span;
    half       = 5'(({1'b0, s_eff} + 6'd1) >> 1);
    km1        = (entry - SEG_AW'(1)) >> 1;
    kup        = ({1'b0, entry} + (SEG_AW + 1)'(1)) >> 1;
    first_full = FIRST_W'(half) + FIRST_W'(s_eff) * FIRST_W'(km1);
    if (entry == '0) begin
      first = 8'd0;
    end else if (first_full > FIRST_W'(255)) begin
      first = 8'd255;
    end else begin
      first = first_full[7:0];
    end
    two_first = {first, 1'b0};
    count     = (two_first >= 9'(NUM_PLANES)) ? 8'd0 : 8'(9'(NUM_PLANES) - two_first);
    k_span    = FIRST_W'(s_eff) * FIRST_W'(kup);
    in_table  = k_span <= FIRST_W'(cfg.max_ring_diff);
    off_sum   = {1'b0, off} + {5'b0, count};
    off_next  = (off_sum > 13'd4095) ? 12'd4095 : off_sum[11:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      BUILD_RUN: begin
        if (!restart && entry == SEG_AW'(MAX_SEGMENTS - 1)) begin
          state_next = BUILD_DONE;
        end
      end
      BUILD_DONE: begin
        if (restart) begin
          state_next = BUILD_RUN;
        end
      end
      default: state_next = BUILD_RUN;
    endcase
  end

  always_comb begin
    busy             = (state == BUILD_RUN);
    wr.en            = busy;
    wr.addr          = entry;
    wr.data.in_table = in_table;
    wr.data.first    = first;
    wr.data.count    = count;
    wr.data.offset   = off;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BUILD_RUN;
      entry <= '0;
      off   <= '0;
    end else begin
      state <= state_next;
      if (restart) begin
        entry <= '0;
        off   <= '0;
      end else if (busy) begin
        entry <= entry + SEG_AW'(1);
        off   <= off_next;
      end
    end
  end

endmodule

// File: design/sba_datapath.sv
// ----------------------------------------------------------------------------
// sba_datapath: quantization, table lookup and address pipeline
// Seven register stages with per-stage hold; the table is read in stage two.
// ----------------------------------------------------------------------------
module sba_datapath
  import sba_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                hold_in,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [23:0]  radius,
  input  logic [17:0]         angle,
  input  logic signed [23:0]  axial_pos,
  input  logic signed [19:0]  tilt,
  output logic                rd_en,
  output logic [SEG_AW-1:0]   rd_addr,
  input  seg_entry_t          rd_data,
  output logic                out_valid,
  input  logic                out_stall,
  output status_t             status,
  output logic [31:0]         address,
  output logic [9:0]          radial_bin,
  output logic [9:0]          view_index,
  output logic [11:0]         plane_index,
  output logic signed [6:0]   segment_number
);

  logic [7:1] v;
  logic [7:1] en;
  logic       accept;
  logic [21:0] rv;

  // stage 1
  logic signed [23:0] s1_radius, s1_axial;
  logic [17:0]        s1_angle;
  logic signed [19:0] s1_tilt;
  // stage 2
  logic [28:0]        s2_pv;
  logic signed [44:0] s2_pt;
  logic signed [12:0] s2_bin;
  logic signed [11:0] s2_zpl;
  // stage 3
  logic [28:0]        s3_pv;
  logic [11:0]        s3_q0;
  logic signed [6:0]  s3_seg;
  logic               s3_oor;
  logic signed [12:0] s3_bin;
  logic signed [11:0] s3_zpl;
  // stage 4
  logic [28:0]        s4_pv;
  logic [29:0]        s4_qd;
  logic [11:0]        s4_q0;
  status_t            s4_status;
  logic [11:0]        s4_plane;
  logic signed [12:0] s4_bin;
  logic signed [6:0]  s4_seg;
  // stage 5
  logic [10:0]        s5_view;
  status_t            s5_status;
  logic [11:0]        s5_plane;
  logic signed [12:0] s5_bin;
  logic signed [6:0]  s5_seg;
  // stage 6
  logic [21:0]        s6_rview;
  logic [31:0]        s6_rvp;
  logic [10:0]        s6_view;
  status_t            s6_status;
  logic [11:0]        s6_plane;
  logic signed [12:0] s6_bin;
  logic signed [6:0]  s6_seg;

  // handshake
  always_comb begin
    en[7] = !v[7] || !out_stall;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
    in_stall  = hold_in || !en[1];
    accept    = in_valid && !in_stall;
    out_valid = v[7];
    rd_en     = en[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= accept;
      end
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rv <= {11'b0, cfg.num_views} * {11'b0, cfg.num_radial};
  end

  // stage 1 logic
  logic [28:0]        pv;
  logic signed [44:0] pt;
  logic signed [24:0] r_sum, z_sum;
  logic signed [12:0] bin;

  always_comb begin
    pv    = {18'b0, cfg.num_views} * {11'b0, s1_angle};
    pt    = $signed({{25{s1_tilt[19]}}, s1_tilt}) * $signed({21'b0, cfg.segment_scale});
    r_sum = $signed({s1_radius[23], s1_radius}) + 25'sd4096;
    z_sum = $signed({s1_axial[23], s1_axial}) + 25'sd4096;
    bin   = $signed({3'b0, cfg.num_radial[10:1]}) + $signed({r_sum[24], r_sum[24:13]});
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_radius <= radius;
      s1_angle  <= angle;
      s1_axial  <= axial_pos;
      s1_tilt   <= tilt;
    end
    if (en[2]) begin
      s2_pv  <= pv;
      s2_pt  <= pt;
      s2_bin <= bin;
      s2_zpl <= z_sum[24:13];
    end
  end

  // stage 2 logic
  logic [44:0]        pq;
  logic signed [45:0] t_sum;
  logic signed [13:0] seg;
  logic               seg_neg;
  logic [13:0]        seg_mag;
  logic [14:0]        idx;
  logic signed [6:0]  seg_clamp;

  always_comb begin
    pq      = {16'b0, s2_pv} * {29'b0, VIEW_RECIP};
    t_sum   = $signed({s2_pt[44], s2_pt}) + 46'sh80000000;
    seg     = t_sum[45:32];
    seg_neg = seg[13];
    seg_mag = seg_neg ? 14'(-seg) : 14'(seg);
    idx     = {seg_mag, 1'b0} - {14'b0, seg_neg};
    rd_addr = idx[SEG_AW-1:0];
    if (seg > 14'sd63) begin
      seg_clamp = 7'sd63;
    end else if (seg < -14'sd63) begin
      seg_clamp = -7'sd63;
    end else begin
      seg_clamp = seg[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_pv  <= s2_pv;
      s3_q0  <= pq[43:32];
      s3_seg <= seg_clamp;
      s3_oor <= idx >= 15'(MAX_SEGMENTS);
      s3_bin <= s2_bin;
      s3_zpl <= s2_zpl;
    end
  end

  // stage 3 logic
  logic [29:0]        qd;
  logic signed [11:0] first_s, last_s;
  logic signed [13:0] plane_sum;
  logic [11:0]        plane_sat;
  status_t            stat;

  always_comb begin
    qd        = {18'b0, s3_q0} * 30'(PI_Q16);
    first_s   = $signed({4'b0, rd_data.first});
    last_s    = $signed({4'b0, rd_data.first}) + $signed({4'b0, rd_data.count}) - 12'sd1;
    plane_sum = $signed({{2{s3_zpl[11]}}, s3_zpl}) - $signed({6'b0, rd_data.first})
              + $signed({2'b0, rd_data.offset});
    plane_sat = (plane_sum > 14'sd4095) ? 12'd4095 : plane_sum[11:0];
    if (s3_bin < 13'sd1 || s3_bin >= $signed({2'b0, cfg.num_radial})) begin
      stat = STAT_RADIAL;
    end else if (s3_oor || !rd_data.in_table) begin
      stat = STAT_SEGMENT;
    end else if (s3_zpl < first_s) begin
      stat = STAT_BELOW;
    end else if (s3_zpl > last_s) begin
      stat = STAT_ABOVE;
    end else begin
      stat = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_pv     <= s3_pv;
      s4_qd     <= qd;
      s4_q0     <= s3_q0;
      s4_status <= stat;
      s4_plane  <= (stat == STAT_OK) ? plane_sat : 12'd0;
      s4_bin    <= s3_bin;
      s4_seg    <= s3_seg;
    end
  end

  // stage 4 logic
  logic [29:0] rem;
  logic [11:0] q;
  logic [10:0] vmax;
  logic [10:0] view;

  always_comb begin
    rem  = {1'b0, s4_pv} - s4_qd;
    q    = s4_q0 + {11'b0, rem >= 30'(PI_Q16)};
    vmax = cfg.num_views - 11'd1;
    if (cfg.num_views == 11'd0) begin
      view = 11'd0;
    end else if (q > {1'b0, vmax}) begin
      view = vmax;
    end else begin
      view = q[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_view   <= view;
      s5_status <= s4_status;
      s5_plane  <= s4_plane;
      s5_bin    <= s4_bin;
      s5_seg    <= s4_seg;
    end
  end

  // stage 5 logic
  logic [21:0] rview;
  logic [33:0] rvp;

  always_comb begin
    rview = {11'b0, cfg.num_radial} * {11'b0, s5_view};
    rvp   = {12'b0, rv} * {22'b0, s5_plane};
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_rview  <= rview;
      s6_rvp    <= rvp[31:0];
      s6_view   <= s5_view;
      s6_status <= s5_status;
      s6_plane  <= s5_plane;
      s6_bin    <= s5_bin;
      s6_seg    <= s5_seg;
    end
  end

  // stage 6 logic
  logic [31:0] addr;
  logic [9:0]  bin_clamp;

  always_comb begin
    addr = {21'b0, s6_bin[10:0]} + {10'b0, s6_rview} + s6_rvp;
    if (s6_bin < 13'sd0) begin
      bin_clamp = 10'd0;
    end else if (s6_bin > 13'sd1023) begin
      bin_clamp = 10'd1023;
    end else begin
      bin_clamp = s6_bin[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      status         <= s6_status;
      address        <= (s6_status == STAT_OK) ? addr : 32'd0;
      radial_bin     <= bin_clamp;
      view_index     <= (s6_view > 11'd1023) ? 10'd1023 : s6_view[9:0];
      plane_index    <= s6_plane;
      segment_number <= s6_seg;
    end
  end

endmodule

// File: design/sinogram_bin_address.sv
// ----------------------------------------------------------------------------
// sinogram_bin_address: line of response to span compressed sinogram address
// Configuration registers, segment table builder, table memory and pipeline.
// ----------------------------------------------------------------------------
// One line of response is taken every clock while in_stall is low, and its
// result passes through the seven register stages of the pipeline, with the
// segment table read in the second stage. After reset, and after every write
// to a defined register, the segment table is rebuilt by a sweep of all 64
// entries, one entry a cycle, during which in_stall stays high.
// ----------------------------------------------------------------------------
module sinogram_bin_address
  import sba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] radius,
  input  logic [17:0]        angle,
  input  logic signed [23:0] axial_pos,
  input  logic signed [19:0] tilt,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [31:0]        address,
  output logic [9:0]         radial_bin,
  output logic [9:0]         view_index,
  output logic [11:0]        plane_index,
  output logic signed [6:0]  segment_number
);

  cfg_t              cfg;
  logic              restart;
  logic              build_busy;
  tbl_wr_t           tbl_wr;
  logic              rd_en;
  logic [SEG_AW-1:0] rd_addr;
  seg_entry_t        rd_data;
  status_t           status_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_views     <= 11'd192;
      cfg.num_radial    <= 11'd256;
      cfg.span          <= 5'd9;
      cfg.max_ring_diff <= 8'd67;
      cfg.segment_scale <= 24'd1048576;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NUM_VIEWS:     cfg.num_views     <= cfg_data[10:0];
        REG_NUM_RADIAL:    cfg.num_radial    <= cfg_data[10:0];
        REG_SPAN:          cfg.span          <= cfg_data[4:0];
        REG_MAX_RING_DIFF: cfg.max_ring_diff <= cfg_data[7:0];
        REG_SEGMENT_SCALE: cfg.segment_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  assign restart = cfg_write && (cfg_index inside {REG_NUM_VIEWS, REG_NUM_RADIAL, REG_SPAN,
                                                   REG_MAX_RING_DIFF, REG_SEGMENT_SCALE});

  sba_table_build u_build (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .wr      (tbl_wr),
    .busy    (build_busy)
  );

  sba_seg_mem u_mem (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sba_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .hold_in        (build_busy),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .radius         (radius),
    .angle          (angle),
    .axial_pos      (axial_pos),
    .tilt           (tilt),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status_q),
    .address        (address),
    .radial_bin     (radial_bin),
    .view_index     (view_index),
    .plane_index    (plane_index),
    .segment_number (segment_number)
  );

  assign status = status_q;

  a_no_beat_in_build: assert property (@(posedge clk) disable iff (rst)
    build_busy |-> in_stall)
    else $error("input beat taken while segment table is rebuilt");

  a_restart_builds: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && (cfg_index == REG_NUM_VIEWS || cfg_index == REG_NUM_RADIAL ||
      cfg_index == REG_SPAN || cfg_index == REG_MAX_RING_DIFF ||
      cfg_index == REG_SEGMENT_SCALE)) |=> build_busy)
    else $error("register write did not start a table rebuild");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STAT_OK) |-> (address == 32'd0 && plane_index == 12'd0))
    else $error("rejected beat carries address or plane");

  a_ok_bin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STAT_OK) |-> radial_bin != 10'd0)
    else $error("accepted beat with radial bin zero");

endmodule
